### hw/rtl/lpr_pkg.sv
// ----------------------------------------------------------------------------
// lpr_pkg: LED panel pixel remap package
// Shared types, register indexes, mode codes and size limits.
// ----------------------------------------------------------------------------
`default_nettype none

package lpr_pkg;

  // size limits; larger register values saturate to these
  localparam logic [6:0] PANEL_DIM_MAX = 7'd64;
  localparam logic [8:0] GRID_DIM_MAX  = 9'd256;

  // configuration register indexes
  localparam logic [2:0] REG_GRID_COLS  = 3'd0;
  localparam logic [2:0] REG_WINDOW_ROW = 3'd1;
  localparam logic [2:0] REG_WINDOW_COL = 3'd2;
  localparam logic [2:0] REG_PANEL_ROWS = 3'd3;
  localparam logic [2:0] REG_PANEL_COLS = 3'd4;
  localparam logic [2:0] REG_MAP_MODE   = 3'd5;
  localparam logic [2:0] REG_SERPENTINE = 3'd6;

  // mapping modes; any other code drops the pixel
  localparam logic [2:0] MODE_STRAIGHT = 3'd0;
  localparam logic [2:0] MODE_SIDEWAYS = 3'd1;
  localparam logic [2:0] MODE_CW       = 3'd2;
  localparam logic [2:0] MODE_CCW      = 3'd3;
  localparam logic [2:0] MODE_HALF     = 3'd4;
  localparam logic [2:0] MODE_OFF      = 3'd5;

  typedef struct packed {
    logic [8:0] grid_cols;
    logic [7:0] window_row;
    logic [7:0] window_col;
    logic [6:0] panel_rows;
    logic [6:0] panel_cols;
    logic [2:0] map_mode;
    logic       serpentine;
  } lpr_cfg_t;

  typedef struct packed {
    logic [15:0] src_index;
    logic [11:0] tgt_index;
    logic        written;
  } lpr_res_t;

endpackage

`default_nettype wire

### hw/rtl/led_panel_pixel_remap_top.sv
// Throughput: one item per cycle while the output does not stall; an accepted item
//   passes the input register, then the result register, which form a two-stage
//   pipeline that advances whenever the result register is empty or taken.
// Reset (async, active low): both stages empty; registers return to grid_cols 1,
//   window 0/0, panel 1x1, straight mode, serpentine off.
// ----------------------------------------------------------------------------
// led_panel_pixel_remap_top: LED panel pixel remap
// Maps a window pixel to its source grid index and its LED panel index,
// with sideways, quarter and half turns, and optional serpentine wiring.
// ----------------------------------------------------------------------------
`default_nettype none

module led_panel_pixel_remap_top
  import lpr_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration write port
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [8:0]  cfg_data_i,
  // pixel position in
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [5:0]  row_i,
  input  wire logic [5:0]  col_i,
  // address pair out
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [15:0]      src_index_o,
  output logic [11:0]      tgt_index_o,
  output logic             written_o
);

  lpr_cfg_t cfg;
  lpr_res_t res;

  // stage 1: input register
  logic       s1_valid_q, s1_valid_d;
  logic [5:0] s1_row_q, s1_col_q;
  // stage 2: result register
  logic       out_valid_q, out_valid_d;
  lpr_res_t   out_res_q;

  logic out_load;   // result register may take a new item
  logic in_take;    // input item accepted this cycle

  lpr_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  lpr_map u_map (
    .row_i (s1_row_q),
    .col_i (s1_col_q),
    .cfg_i (cfg),
    .res_o (res)
  );

  // result register loads when empty or being drained
  assign out_load   = !out_valid_q || !out_stall_i;
  // input stage holds only when it carries an item that cannot move on
  assign in_stall_o = s1_valid_q && !out_load;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d  = s1_valid_q;
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = s1_valid_q;
    end
    if (!in_stall_o) begin
      s1_valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_row_q <= row_i;
      s1_col_q <= col_i;
    end
    if (out_load && s1_valid_q) begin
      out_res_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign src_index_o = out_res_q.src_index;
  assign tgt_index_o = out_res_q.tgt_index;
  assign written_o   = out_res_q.written;

  // a dropped pixel carries a zero panel index
  a_drop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_res_q.written |-> out_res_q.tgt_index == 12'd0)
    else $error("dropped pixel with nonzero panel index");

  // the input side stalls only while stage 1 holds an item
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && out_valid_q)
    else $error("input stalled with room in the pipeline");

  // a stalled result is never lost
  a_out_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |=> out_valid_q)
    else $error("stalled result dropped");

  // a held stage-1 item is not overwritten
  a_s1_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> s1_valid_q && $stable(s1_row_q) && $stable(s1_col_q))
    else $error("held input item changed");

endmodule

`default_nettype wire

### hw/rtl/lpr_cfg_regs.sv
// ----------------------------------------------------------------------------
// lpr_cfg_regs: configuration register file
// Seven write-only registers, written by index, low bits of the data kept.
// ----------------------------------------------------------------------------
`default_nettype none

module lpr_cfg_regs
  import lpr_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [2:0] cfg_index_i,
  input  wire logic [8:0] cfg_data_i,
  output lpr_cfg_t        cfg_o
);

  lpr_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_GRID_COLS:  cfg_d.grid_cols  = cfg_data_i;
        REG_WINDOW_ROW: cfg_d.window_row = cfg_data_i[7:0];
        REG_WINDOW_COL: cfg_d.window_col = cfg_data_i[7:0];
        REG_PANEL_ROWS: cfg_d.panel_rows = cfg_data_i[6:0];
        REG_PANEL_COLS: cfg_d.panel_cols = cfg_data_i[6:0];
        REG_MAP_MODE:   cfg_d.map_mode   = cfg_data_i[2:0];
        REG_SERPENTINE: cfg_d.serpentine = cfg_data_i[0];
        default:        cfg_d = cfg_q;   // unmapped index
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.grid_cols  <= 9'd1;
      cfg_q.window_row <= 8'd0;
      cfg_q.window_col <= 8'd0;
      cfg_q.panel_rows <= 7'd1;
      cfg_q.panel_cols <= 7'd1;
      cfg_q.map_mode   <= MODE_STRAIGHT;
      cfg_q.serpentine <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

### hw/rtl/lpr_map.sv
// ----------------------------------------------------------------------------
// lpr_map: pixel address mapper
// Combinational source and panel index computation for one pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module lpr_map
  import lpr_pkg::*;
(
  input  wire logic [5:0] row_i,
  input  wire logic [5:0] col_i,
  input  lpr_cfg_t        cfg_i,
  output lpr_res_t        res_o
);

  logic [8:0]        stride;
  logic [6:0]        pr, pc;
  logic [8:0]        abs_row;
  logic [17:0]       src_prod;
  logic [17:0]       src_sum;
  logic signed [8:0] r9, c9, pr9, pc9;
  logic signed [8:0] tr, tc, tc_fin;
  logic              mode_ok, in_panel, ok;
  logic [12:0]       tgt_sum;

  // saturate sizes
  assign stride = (cfg_i.grid_cols > GRID_DIM_MAX) ? GRID_DIM_MAX : cfg_i.grid_cols;
  assign pr = (cfg_i.panel_rows > PANEL_DIM_MAX) ? PANEL_DIM_MAX : cfg_i.panel_rows;
  assign pc = (cfg_i.panel_cols > PANEL_DIM_MAX) ? PANEL_DIM_MAX : cfg_i.panel_cols;

  // source index: (window_row + row) * stride + window_col + col, mod 2^16
  assign abs_row  = {1'b0, cfg_i.window_row} + {3'b0, row_i};
  assign src_prod = abs_row * stride;
  assign src_sum  = src_prod + {10'b0, cfg_i.window_col} + {12'b0, col_i};

  assign r9  = $signed({3'b0, row_i});
  assign c9  = $signed({3'b0, col_i});
  assign pr9 = $signed({2'b0, pr});
  assign pc9 = $signed({2'b0, pc});

  always_comb begin
    tr      = '0;
    tc      = '0;
    mode_ok = 1'b1;
    unique case (cfg_i.map_mode)
      MODE_STRAIGHT: begin
        tr = r9;
        tc = c9;
      end
      MODE_SIDEWAYS: begin
        tr = pr9 - 9'sd1 - c9;
        tc = r9;
      end
      MODE_CW: begin
        mode_ok = (pr == pc);
        tr      = c9;
        tc      = pc9 - 9'sd1 - r9;
      end
      MODE_CCW: begin
        mode_ok = (pr == pc);
        tr      = pr9 - 9'sd1 - c9;
        tc      = r9;
      end
      MODE_HALF: begin
        tr = pr9 - 9'sd1 - r9;
        tc = pc9 - 9'sd1 - c9;
      end
      default: mode_ok = 1'b0;   // off and unused codes
    endcase
  end

  assign in_panel = !tr[8] && (tr < pr9) && !tc[8] && (tc < pc9);
  assign ok       = mode_ok && in_panel;

  // zigzag wiring: even rows run backwards
  assign tc_fin = (cfg_i.serpentine && !tr[0]) ? (pc9 - 9'sd1 - tc) : tc;

  assign tgt_sum = ({7'b0, tr[5:0]} * {6'b0, pc}) + {7'b0, tc_fin[5:0]};

  assign res_o.src_index = src_sum[15:0];
  assign res_o.tgt_index = ok ? tgt_sum[11:0] : 12'd0;
  assign res_o.written   = ok;

endmodule

`default_nettype wire

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: LED panel pixel remap
// Directed and random pixel positions under many register settings, with
// random gaps on the input and random stalls on the output. A scoreboard
// predicts the source and panel indexes of every accepted item and checks
// each result in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

import lpr_pkg::*;

class remap_scoreboard;
  // register copy, reset values
  logic [8:0] grid_cols  = 9'd1;
  logic [7:0] window_row = 8'd0;
  logic [7:0] window_col = 8'd0;
  logic [6:0] panel_rows = 7'd1;
  logic [6:0] panel_cols = 7'd1;
  logic [2:0] map_mode   = MODE_STRAIGHT;
  logic       serpentine = 1'b0;

  lpr_res_t    expected_q[$];
  int unsigned mismatches = 0;

  function void set_reg(logic [2:0] idx, logic [8:0] data);
    case (idx)
      REG_GRID_COLS:  grid_cols  = data;
      REG_WINDOW_ROW: window_row = data[7:0];
      REG_WINDOW_COL: window_col = data[7:0];
      REG_PANEL_ROWS: panel_rows = data[6:0];
      REG_PANEL_COLS: panel_cols = data[6:0];
      REG_MAP_MODE:   map_mode   = data[2:0];
      REG_SERPENTINE: serpentine = data[0];
      default: ;
    endcase
  endfunction

  function lpr_res_t remap_pixel(logic [5:0] r, logic [5:0] c);
    int       stride, pr, pc, tr, tc, src, tgt;
    logic     ok;
    lpr_res_t res;
    stride = (grid_cols > GRID_DIM_MAX) ? int'(GRID_DIM_MAX) : int'(grid_cols);
    pr = (panel_rows > PANEL_DIM_MAX) ? int'(PANEL_DIM_MAX) : int'(panel_rows);
    pc = (panel_cols > PANEL_DIM_MAX) ? int'(PANEL_DIM_MAX) : int'(panel_cols);
    src = (int'(window_row) + int'(r)) * stride + int'(window_col) + int'(c);
    ok  = 1'b1;
    tr  = 0;
    tc  = 0;
    tgt = 0;
    case (map_mode)
      MODE_STRAIGHT: begin
        tr = int'(r);
        tc = int'(c);
      end
      MODE_SIDEWAYS: begin
        tr = pr - 1 - int'(c);
        tc = int'(r);
      end
      MODE_CW: begin
        ok = (pr == pc);
        tr = int'(c);
        tc = pc - 1 - int'(r);
      end
      MODE_CCW: begin
        ok = (pr == pc);
        tr = pr - 1 - int'(c);
        tc = int'(r);
      end
      MODE_HALF: begin
        tr = pr - 1 - int'(r);
        tc = pc - 1 - int'(c);
      end
      default: ok = 1'b0;  // off and unused codes drop the pixel
    endcase
    if (ok && (tr < 0 || tr >= pr || tc < 0 || tc >= pc)) ok = 1'b0;
    if (ok) begin
      // zigzag wiring: even panel rows run backwards
      if (serpentine && (tr % 2 == 0)) tc = pc - 1 - tc;
      tgt = tr * pc + tc;
    end
    res.src_index = src[15:0];
    res.tgt_index = tgt[11:0];
    res.written   = ok;
    return res;
  endfunction

  function void note_pixel(logic [5:0] r, logic [5:0] c);
    expected_q.push_back(remap_pixel(r, c));
  endfunction

  function void check_result(lpr_res_t got);
    lpr_res_t want;
    if (expected_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: result with no item pending: src %0d tgt %0d written %0b",
                 $realtime, got.src_index, got.tgt_index, got.written);
      return;
    end
    want = expected_q.pop_front();
    if (got.src_index !== want.src_index || got.tgt_index !== want.tgt_index ||
        got.written !== want.written) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: mismatch: src %0d/%0d tgt %0d/%0d written %0b/%0b (exp/got)",
                 $realtime, want.src_index, got.src_index, want.tgt_index,
                 got.tgt_index, want.written, got.written);
    end
  endfunction
endclass

module testbench;

  localparam int unsigned RANDOM_ITEMS = 1300;
  localparam int unsigned QUIET_LIMIT  = 2000;
  // mode code above the defined set, must drop like off
  localparam logic [2:0]  MODE_UNUSED_HI = 3'd7;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [2:0]  cfg_index_i = REG_GRID_COLS;
  logic [8:0]  cfg_data_i  = '0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic [5:0]  row_i       = '0;
  logic [5:0]  col_i       = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [15:0] src_index_o;
  logic [11:0] tgt_index_o;
  logic        written_o;

  remap_scoreboard sb = new();

  bit          calm = 1'b0;       // no gaps or stalls while set
  int unsigned random_sent  = 0;
  int unsigned quiet_cycles = 0;

  led_panel_pixel_remap_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .row_i       (row_i),
    .col_i       (col_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .src_index_o (src_index_o),
    .tgt_index_o (tgt_index_o),
    .written_o   (written_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned gap_len();
    int unsigned pick;
    if (calm) return 0;
    pick = $urandom_range(0, 15);
    if (pick < 8) return 0;
    if (pick < 14) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_pixel(logic [5:0] r, logic [5:0] c);
    int unsigned gap;
    gap = gap_len();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    row_i      <= r;
    col_i      <= c;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_pixel(r, c);
  endtask

  task automatic drain_pixels();
    in_valid_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [8:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    sb.set_reg(idx, data);
  endtask

  // registers change only with the pipeline empty
  task automatic set_config(logic [8:0] gc, logic [7:0] wr, logic [7:0] wc,
                            logic [6:0] nr, logic [6:0] nc, logic [2:0] mode,
                            logic serp);
    drain_pixels();
    write_reg(REG_GRID_COLS, gc);
    write_reg(REG_WINDOW_ROW, {1'b0, wr});
    write_reg(REG_WINDOW_COL, {1'b0, wc});
    write_reg(REG_PANEL_ROWS, {2'b0, nr});
    write_reg(REG_PANEL_COLS, {2'b0, nc});
    write_reg(REG_MAP_MODE, {6'b0, mode});
    write_reg(REG_SERPENTINE, {8'b0, serp});
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_phase();
    logic [8:0]  gc;
    logic [6:0]  nr, nc;
    logic [2:0]  mode;
    int unsigned sel, count, span;
    logic [5:0]  r, c;
    sel  = $urandom_range(0, 9);
    gc   = (sel == 0) ? 9'($urandom) : 9'($urandom_range(1, 256));
    nr   = (sel == 1) ? 7'($urandom) : 7'($urandom_range(1, 64));
    nc   = (sel == 2) ? 7'($urandom) : 7'($urandom_range(1, 64));
    if ($urandom_range(0, 2) == 0) nc = nr;   // quarter turns need square panels
    mode = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(MODE_OFF, MODE_UNUSED_HI))
                                       : 3'($urandom_range(MODE_STRAIGHT, MODE_HALF));
    calm = ($urandom_range(0, 3) == 0);
    set_config(gc, 8'($urandom), 8'($urandom), nr, nc, mode, 1'($urandom));
    // most positions land on the panel, the rest anywhere in the window
    span = (nr > nc) ? 32'(nr) : 32'(nc);
    if (span > 64) span = 64;
    if (span == 0) span = 1;
    count = $urandom_range(20, 80);
    repeat (count) begin
      if ($urandom_range(0, 3) != 0) begin
        r = 6'($urandom_range(0, span - 1));
        c = 6'($urandom_range(0, span - 1));
      end else begin
        r = 6'($urandom);
        c = 6'($urandom);
      end
      send_pixel(r, c);
      random_sent++;
    end
  endtask

  // output stall pattern
  initial begin
    int unsigned n;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      n = gap_len();
      if (n != 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result({src_index_o, tgt_index_o, written_o});
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: 1x1 panel, straight
    send_pixel(6'd0, 6'd0);
    send_pixel(6'd63, 6'd63);
    // largest grid and window, source index wraps
    set_config(GRID_DIM_MAX, 8'd255, 8'd255, 7'd64, 7'd64, MODE_STRAIGHT, 1'b0);
    send_pixel(6'd0, 6'd0);
    send_pixel(6'd63, 6'd63);
    send_pixel(6'd0, 6'd63);
    send_pixel(6'd63, 6'd0);
    // sideways turn on a tall panel, one position off the panel
    set_config(9'd40, 8'd3, 8'd7, 7'd64, 7'd32, MODE_SIDEWAYS, 1'b1);
    send_pixel(6'd5, 6'd10);
    send_pixel(6'd40, 6'd3);
    // clockwise, oversized grid stride
    set_config(9'd511, 8'd0, 8'd0, 7'd8, 7'd8, MODE_CW, 1'b0);
    send_pixel(6'd1, 6'd2);
    send_pixel(6'd9, 6'd0);
    // clockwise on a non-square panel, zero stride
    set_config(9'd0, 8'd10, 8'd20, 7'd8, 7'd4, MODE_CW, 1'b0);
    send_pixel(6'd0, 6'd0);
    // counter clockwise with zigzag wiring
    set_config(9'd64, 8'd0, 8'd0, 7'd64, 7'd64, MODE_CCW, 1'b1);
    send_pixel(6'd0, 6'd0);
    send_pixel(6'd63, 6'd63);
    // half turn, both panel sizes saturate
    set_config(9'd100, 8'd1, 8'd1, 7'd127, 7'd100, MODE_HALF, 1'b1);
    send_pixel(6'd0, 6'd0);
    send_pixel(6'd63, 6'd63);
    // off and an unused mode code
    set_config(9'd1, 8'd0, 8'd0, 7'd16, 7'd16, MODE_OFF, 1'b0);
    send_pixel(6'd3, 6'd3);
    set_config(9'd1, 8'd0, 8'd0, 7'd16, 7'd16, MODE_UNUSED_HI, 1'b0);
    send_pixel(6'd3, 6'd3);
    // zero panel rows
    set_config(9'd1, 8'd0, 8'd0, 7'd0, 7'd16, MODE_STRAIGHT, 1'b0);
    send_pixel(6'd0, 6'd0);

    while (random_sent < RANDOM_ITEMS) random_phase();

    drain_pixels();
    repeat (10) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
